@@ src/assert_macros.svh @@
// Assertion macros shared by the sharpen filter RTL.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SHP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ src/sharp3_pkg.sv @@
// Package for the 3x3 sharpen filter: defaults, register indexes, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sharp3_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_BITS-1:0] RST_IMAGE_WIDTH  = 12'd1920;
  localparam logic [CFG_DATA_BITS-1:0] RST_IMAGE_HEIGHT = 12'd1080;

  // result queue depth; covers the two pipeline stages plus output slack
  localparam int OUT_FIFO_DEPTH = 4;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } line_ctl_t;

endpackage

`default_nettype wire

@@ src/sharpen_3x3_clamped.sv @@
// 3x3 sharpen filter (9 x center minus 8 neighbors) with replicated border.
// Pixels enter on the in_ request channel in raster order, one per cycle
// while in_ready is high; results leave on the out_ request channel, one
// per pixel, with end_of_frame set on the frame's last pixel. A result
// appears once the pixel one row plus one column later has been taken, so
// the last row is drained with image_width + 1 flush requests (a pixel sent in
// that phase counts as a flush, a flush sent while pixels are due is dropped).
// After the request that completes a result, it is registered and queued before
// it reaches out_. Throughput is one request per cycle while in_ready is high:
// each request does one read of the two line stores and one write back at the
// same column, and the next request's read overlaps that write through a bypass
// register. A 4-entry result queue absorbs receiver stalls; in_ready drops only
// when results in flight plus queued reach 4, so a stalled receiver costs no
// data. Reset (rst_n, synchronous) restores 1920 x 1080, clears counters,
// pipeline and queue; line store contents are not cleared and need not be. A
// cfg_ write (index 0 width, 1 height, others ignored) restarts the frame; the
// user must issue it only while the block is idle; the block does not check.
// Depends on sharp3_pkg, sharp3_line_store, sharp3_out_fifo, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sharpen_3x3_clamped #(
  parameter int MAX_WIDTH  = sharp3_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = sharp3_pkg::DEF_PIXEL_BITS
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     cfg_wr_en,
  input  wire  [sharp3_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire  [sharp3_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data,
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire  [PIXEL_BITS-1:0]                   in_pixel_in,
  input  wire                                     in_flush,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic signed [PIXEL_BITS+4:0]            out_sharpened,
  output logic                                    out_end_of_frame
);
  import sharp3_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = CFG_DATA_BITS + 1;
  localparam int PB   = PIXEL_BITS;
  localparam int SW   = PB + 2;
  localparam int TW   = PB + 4;
  localparam int OW   = PB + 5;
  localparam int CNTW = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int PNW  = CNTW + 1;

  // configuration
  logic [CFG_DATA_BITS-1:0] width_r, height_r;
  logic [CW:0]              eff_w;
  logic [CFG_DATA_BITS-1:0] eff_h;

  // frame position
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // request decode
  logic accept, drain, skip, row_end, stop, work, res_a, res_b, last_col;

  // first stage: line store data arrives
  logic          s1_work_r, s1_resa_r, s1_resb_r, s1_eof_r;
  logic          s1_drain_r, s1_rle1_r, s1_cis1_r, s1_w1_r, s1_fwd_r;
  logic [CW-1:0] s1_col_r;
  logic [PB-1:0] s1_pix_r, fwd_a_r, fwd_b_r;
  logic [PB-1:0] ls_rd_a, ls_rd_b, mem_a, mem_b;
  logic [PB-1:0] cur [3];
  logic [PB-1:0] lv [3];
  logic [PB-1:0] cv [3];
  logic [PB-1:0] rv [3];
  logic [PB-1:0] win_r [6];
  logic          fwd_nxt;
  line_ctl_t     ls_ctl;

  // second stage: column sums
  logic          s2_v_r, s2_eof_r;
  logic [SW-1:0] s2_ls_r, s2_cs_r, s2_rs_r;
  logic [PB-1:0] s2_mid_r;
  logic [TW-1:0] total, ten;
  logic [OW-1:0] result;

  logic [CNTW-1:0] fifo_cnt;
  logic [PNW-1:0]  pend_cnt;
  logic [OW:0]     fifo_dout;

  // ---------------------------------------------------------------- config
  always_comb begin
    if (width_r == '0) begin
      eff_w = (CW+1)'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      eff_w = (CW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW+1)'(width_r);
    end
    eff_h = (height_r == '0) ? CFG_DATA_BITS'(1) : height_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_wr_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- decode
  assign pend_cnt = PNW'(fifo_cnt) + PNW'(s1_resa_r | s1_resb_r) + PNW'(s2_v_r);
  assign in_ready = (pend_cnt < PNW'(OUT_FIFO_DEPTH));
  assign accept   = in_valid && in_ready;

  always_comb begin
    drain    = (row_r >= {1'b0, eff_h});
    row_end  = (row_r == ({1'b0, eff_h} + RW'(1)));
    skip     = !drain && in_flush;
    last_col = (({1'b0, col_r} + (CW+1)'(1)) == eff_w);
    // end-of-row result for the previous row's last pixel
    res_a    = !skip && (col_r == '0) && (row_r >= RW'(2));
    stop     = !skip && (col_r == '0) && row_end;
    work     = !skip && !stop;
    res_b    = work && (col_r != '0) && (row_r != '0);

    col_nxt = col_r;
    row_nxt = row_r;
    if (stop) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (work) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_wr_en) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // same column written by the request in flight: bypass the store
  assign fwd_nxt = s1_work_r && !s1_drain_r && (s1_col_r == col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_work_r <= 1'b0;
      s1_resa_r <= 1'b0;
      s1_resb_r <= 1'b0;
    end else begin
      s1_work_r <= accept && work;
      s1_resa_r <= accept && res_a;
      s1_resb_r <= accept && res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_eof_r   <= res_a && row_end;
      s1_drain_r <= drain;
      s1_rle1_r  <= (row_r <= RW'(1));
      s1_cis1_r  <= (col_r == CW'(1));
      s1_w1_r    <= (eff_w == (CW+1)'(1));
      s1_col_r   <= col_r;
      s1_pix_r   <= in_pixel_in;
      s1_fwd_r   <= fwd_nxt;
      fwd_a_r    <= s1_pix_r;
      fwd_b_r    <= mem_a;
    end
  end

  // ---------------------------------------------------------- line stores
  assign ls_ctl.rd_en = accept && work;
  assign ls_ctl.wr_en = s1_work_r && !s1_drain_r;

  sharp3_line_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_store (
    .clk     (clk),
    .ctl     (ls_ctl),
    .rd_addr (col_r),
    .wr_addr (s1_col_r),
    .wr_a    (s1_pix_r),
    .wr_b    (mem_a),
    .rd_a    (ls_rd_a),
    .rd_b    (ls_rd_b)
  );

  // ---------------------------------------------------------- window stage
  always_comb begin
    mem_a  = s1_fwd_r ? fwd_a_r : ls_rd_a;
    mem_b  = s1_fwd_r ? fwd_b_r : ls_rd_b;
    // vertical clamp at top and bottom
    cur[1] = mem_a;
    cur[0] = s1_rle1_r ? mem_a : mem_b;
    cur[2] = s1_drain_r ? mem_a : s1_pix_r;
    for (int i = 0; i < 3; i++) begin
      cv[i] = win_r[3+i];
      if (s1_resa_r) begin
        lv[i] = s1_w1_r ? win_r[3+i] : win_r[i];
        rv[i] = win_r[3+i];
      end else begin
        lv[i] = s1_cis1_r ? win_r[3+i] : win_r[i];
        rv[i] = cur[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_work_r) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i]   <= win_r[3+i];
        win_r[3+i] <= cur[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_resa_r || s1_resb_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_eof_r <= s1_eof_r && s1_resa_r;
    s2_ls_r  <= SW'(lv[0]) + SW'(lv[1]) + SW'(lv[2]);
    s2_cs_r  <= SW'(cv[0]) + SW'(cv[1]) + SW'(cv[2]);
    s2_rs_r  <= SW'(rv[0]) + SW'(rv[1]) + SW'(rv[2]);
    s2_mid_r <= cv[1];
  end

  // ---------------------------------------------------------- result stage
  assign total  = TW'(s2_ls_r) + TW'(s2_cs_r) + TW'(s2_rs_r);
  assign ten    = TW'({s2_mid_r, 3'b000}) + TW'({s2_mid_r, 1'b0});
  assign result = {1'b0, ten} - {1'b0, total};

  sharp3_out_fifo #(
    .WIDTH (OW + 1),
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s2_v_r),
    .din        ({s2_eof_r, result}),
    .pop_ready  (out_ready),
    .dout_valid (out_valid),
    .dout       (fifo_dout),
    .count      (fifo_cnt)
  );

  assign out_end_of_frame = fifo_dout[OW];
  assign out_sharpened    = signed'(fifo_dout[OW-1:0]);

  // ---------------------------------------------------------- assertions
  `SHP_ASSERT(a_credit_bound, pend_cnt <= PNW'(OUT_FIFO_DEPTH), "result credit overrun")
  `SHP_ASSERT_IMPL(a_stall_has_output, !in_ready, out_valid, "input stalled with empty queue")
  `SHP_ASSERT_IMPL(a_eof_from_row_end, s2_v_r && s2_eof_r, $past(s1_resa_r),
                   "end of frame not from a row-end result")

endmodule

`default_nettype wire

@@ src/sharp3_line_store.sv @@
// Two line stores (previous row and the row before it), synchronous read.
// Depends on sharp3_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module sharp3_line_store #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 16
) (
  input  wire                            clk,
  input  wire sharp3_pkg::line_ctl_t     ctl,
  input  wire  [$clog2(MAX_WIDTH)-1:0]   rd_addr,
  input  wire  [$clog2(MAX_WIDTH)-1:0]   wr_addr,
  input  wire  [PIXEL_BITS-1:0]          wr_a,
  input  wire  [PIXEL_BITS-1:0]          wr_b,
  output logic [PIXEL_BITS-1:0]          rd_a,
  output logic [PIXEL_BITS-1:0]          rd_b
);
  import sharp3_pkg::*;

  logic [PIXEL_BITS-1:0] mem_a [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] mem_b [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_a[wr_addr] <= wr_a;
      mem_b[wr_addr] <= wr_b;
    end
  end

  // read-before-write; the caller forwards same-address hazards
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_a <= mem_a[rd_addr];
      rd_b <= mem_b[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/sharp3_out_fifo.sv @@
// Small result queue in front of the output port.
// Depends on sharp3_pkg only for the shared import convention.
`timescale 1ns / 1ps
`default_nettype none

module sharp3_out_fifo #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 4
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          push,
  input  wire  [WIDTH-1:0]             din,
  input  wire                          pop_ready,
  output logic                         dout_valid,
  output logic [WIDTH-1:0]             dout,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import sharp3_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             pop;

  assign dout_valid = (cnt_r != '0);
  assign dout       = slot_r[rd_ptr_r];
  assign count      = cnt_r;
  assign pop        = dout_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire
